// ----- design/assert_macros.svh -----
// Assertion macros shared by the sequencer modules.
// In synthesis builds they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/sasu_pkg.sv -----
package sasu_pkg;

	// Frame table depth, fixed by the 4-bit slot and frame fields.
	localparam int MAX_FRAMES = 16;
	localparam int FRAME_W    = 4;
	localparam int COUNT_W    = 5;
	localparam int SPRITE_W   = 16;
	localparam int ACTION_W   = 8;
	localparam int TIME_W     = 16;
	localparam int ACCUM_W    = 20;
	localparam int ENTRY_W    = SPRITE_W + ACTION_W;

	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_PLAY      = 3'd1,
		CMD_PAUSE     = 3'd2,
		CMD_RESUME    = 3'd3,
		CMD_STOP      = 3'd4,
		CMD_REW_START = 3'd5,
		CMD_REW_END   = 3'd6,
		CMD_LOAD      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		RUN_STOPPED = 2'd0,
		RUN_PLAYING = 2'd1,
		RUN_PAUSED  = 2'd2
	} run_t;

	typedef enum logic [1:0] {
		LOOP_NONE     = 2'd0,
		LOOP_RESTART  = 2'd1,
		LOOP_PINGPONG = 2'd2
	} loop_t;

	typedef enum logic [1:0] {
		CFG_FRAME_COUNT  = 2'd0,
		CFG_FRAME_PERIOD = 2'd1,
		CFG_MAX_CYCLES   = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_EXEC,
		SEQ_WAIT,
		SEQ_ENTER,
		SEQ_STEP,
		SEQ_STATUS
	} seq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic exec;
		logic enter;
		logic step;
		logic emit_status;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic tick_go;
		logic stopped;
		logic step_ok;
	} sts_t;

endpackage

// ----- design/sasu_ram.sv -----
module sasu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/sasu_ctrl.sv -----
`include "assert_macros.svh"

module sasu_ctrl import sasu_pkg::*; #(
	parameter int MAX_STEPS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output ctl_t ctl
);

	localparam int STEP_W = $clog2(MAX_STEPS + 1);

	seq_state_t state_q, state_d;
	logic [STEP_W-1:0] steps_q;
	logic step_more;

	assign step_more = sts.step_ok && (steps_q != STEP_W'(MAX_STEPS));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_d = SEQ_EXEC;
				end
			end
			SEQ_EXEC: begin
				if (sts.tick_go) begin
					state_d = SEQ_ENTER;
				end else if (sts.cmd == CMD_LOAD) begin
					state_d = SEQ_WAIT;
				end else begin
					state_d = SEQ_STATUS;
				end
			end
			SEQ_WAIT: state_d = SEQ_STATUS;
			SEQ_ENTER: begin
				state_d = sts.stopped ? SEQ_STATUS : SEQ_STEP;
			end
			SEQ_STEP: begin
				state_d = step_more ? SEQ_ENTER : SEQ_STATUS;
			end
			SEQ_STATUS: state_d = SEQ_IDLE;
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		busy = (state_q != SEQ_IDLE);
		unique case (state_q)
			SEQ_IDLE:   ctl.latch = start;
			SEQ_EXEC:   ctl.exec = 1'b1;
			SEQ_ENTER:  ctl.enter = 1'b1;
			SEQ_STEP:   ctl.step = step_more;
			SEQ_STATUS: ctl.emit_status = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			steps_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SEQ_EXEC) begin
				steps_q <= '0;
			end else if (ctl.step) begin
				steps_q <= steps_q + STEP_W'(1);
			end
		end
	end

	`ASSERT_IMP(a_steps_bound, clk, arst_n, 1'b1, steps_q <= STEP_W'(MAX_STEPS))
	`ASSERT_NXT(a_step_end, clk, arst_n, state_q == SEQ_STEP && !step_more, state_q == SEQ_STATUS)
	`ASSERT_NXT(a_enter_follows, clk, arst_n, ctl.step, state_q == SEQ_ENTER)

endmodule

// ----- design/sasu_dp.sv -----
`include "assert_macros.svh"

module sasu_dp import sasu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl,
	output sts_t                sts,
	input  logic [2:0]          command,
	input  logic [TIME_W-1:0]   delta_time,
	input  logic [1:0]          play_loop,
	input  logic                play_reverse,
	input  logic [FRAME_W-1:0]  frame_slot,
	input  logic [SPRITE_W-1:0] sprite_value,
	input  logic [ACTION_W-1:0] action_value,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                result_valid,
	output logic                kind,
	output logic [FRAME_W-1:0]  action_frame,
	output logic [ACTION_W-1:0] action_code,
	output logic [SPRITE_W-1:0] sprite_index,
	output logic [1:0]          run_state,
	output logic [FRAME_W-1:0]  current_frame,
	output logic                changed,
	output logic                last_result
);

	// Latched item fields.
	cmd_t                cmd_q;
	logic [TIME_W-1:0]   delta_q;
	logic [1:0]          loop_in_q;
	logic                rev_in_q;
	logic [FRAME_W-1:0]  slot_q;
	logic [SPRITE_W-1:0] sprite_q;
	logic [ACTION_W-1:0] action_q;

	// Configuration.
	logic [COUNT_W-1:0] frame_count_q;
	logic [15:0]        frame_period_q;
	logic [15:0]        max_cycles_q;

	// Sequencer state.
	logic [FRAME_W-1:0] cursor_q, cursor_d;
	logic               entered_valid_q, entered_valid_d;
	logic [FRAME_W-1:0] entered_q, entered_d;
	run_t               run_q, run_d;
	loop_t              loop_q, loop_d;
	logic               rev_q, rev_d;
	logic [15:0]        pass_q, pass_d;
	logic [ACCUM_W-1:0] accum_q, accum_d;
	logic               changed_q, changed_d;

	logic [COUNT_W-1:0] nf, ncfg;
	logic [FRAME_W-1:0] last;
	logic [ACCUM_W:0]   accum_sum;
	logic [15:0]        pass_inc;
	logic               pass_limit;
	loop_t              loop_eff;
	logic [ENTRY_W-1:0] rd_entry;
	logic [SPRITE_W-1:0] rd_sprite;
	logic [ACTION_W-1:0] rd_action;
	logic               fire;
	logic               ram_we;

	assign nf   = (frame_count_q > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : frame_count_q;
	assign ncfg = (cfg_data[COUNT_W-1:0] > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
		: cfg_data[COUNT_W-1:0];
	assign last = FRAME_W'(nf - COUNT_W'(1));

	assign accum_sum  = {1'b0, accum_q} + (ACCUM_W + 1)'(delta_q);
	assign pass_inc   = (pass_q == 16'hFFFF) ? pass_q : pass_q + 16'd1;
	assign pass_limit = (max_cycles_q != 16'd0) && (pass_inc >= max_cycles_q);
	assign loop_eff   = pass_limit ? LOOP_NONE : loop_q;

	assign rd_sprite = rd_entry[ENTRY_W-1:ACTION_W];
	assign rd_action = rd_entry[ACTION_W-1:0];
	assign fire = (!entered_valid_q || entered_q != cursor_q) && (rd_action != '0);
	assign ram_we = ctl.exec && (cmd_q == CMD_LOAD);

	assign sts.cmd     = cmd_q;
	assign sts.tick_go = (cmd_q == CMD_TICK) && (run_q == RUN_PLAYING) && (nf != '0);
	assign sts.stopped = (run_q == RUN_STOPPED);
	assign sts.step_ok = (frame_period_q != 16'd0) && (accum_q >= ACCUM_W'(frame_period_q));

	always_comb begin
		cursor_d        = cursor_q;
		entered_valid_d = entered_valid_q;
		entered_d       = entered_q;
		run_d           = run_q;
		loop_d          = loop_q;
		rev_d           = rev_q;
		pass_d          = pass_q;
		accum_d         = accum_q;
		changed_d       = changed_q;

		if (cfg_valid && cfg_index == CFG_FRAME_COUNT) begin
			if (ncfg == '0) begin
				cursor_d = '0;
			end else if ({1'b0, cursor_q} >= ncfg) begin
				cursor_d = FRAME_W'(ncfg - COUNT_W'(1));
			end
		end

		if (ctl.exec) begin
			changed_d = 1'b0;
			unique case (cmd_q)
				CMD_TICK: begin
					if (run_q == RUN_PLAYING) begin
						changed_d = 1'b1;
						if (nf == '0) begin
							run_d = RUN_STOPPED;
						end else begin
							accum_d = accum_sum[ACCUM_W] ? '1 : accum_sum[ACCUM_W-1:0];
						end
					end
				end
				CMD_PLAY: begin
					run_d           = RUN_STOPPED;
					loop_d          = LOOP_NONE;
					rev_d           = 1'b0;
					entered_valid_d = 1'b0;
					entered_d       = '0;
					pass_d          = '0;
					accum_d         = '0;
					if (nf != '0 && frame_period_q != 16'd0) begin
						case (loop_in_q)
							LOOP_RESTART:  loop_d = LOOP_RESTART;
							LOOP_PINGPONG: loop_d = LOOP_PINGPONG;
							default:       loop_d = LOOP_NONE;
						endcase
						rev_d = rev_in_q;
						run_d = RUN_PLAYING;
					end
				end
				CMD_PAUSE: begin
					if (run_q == RUN_PLAYING) run_d = RUN_PAUSED;
				end
				CMD_RESUME: begin
					if (run_q == RUN_PAUSED) run_d = RUN_PLAYING;
				end
				CMD_STOP:      run_d = RUN_STOPPED;
				CMD_REW_START: cursor_d = '0;
				CMD_REW_END:   cursor_d = (nf != '0) ? last : '0;
				CMD_LOAD: ;
				default: ;
			endcase
		end

		if (ctl.enter && (!entered_valid_q || entered_q != cursor_q)) begin
			entered_valid_d = 1'b1;
			entered_d       = cursor_q;
		end

		if (ctl.step) begin
			accum_d = accum_q - ACCUM_W'(frame_period_q);
			if (!rev_q) begin
				if (cursor_q == last) begin
					pass_d = pass_inc;
					loop_d = loop_eff;
					case (loop_eff)
						LOOP_RESTART: cursor_d = '0;
						LOOP_PINGPONG: begin
							rev_d = 1'b1;
							if (cursor_q != '0) cursor_d = cursor_q - FRAME_W'(1);
						end
						default: run_d = RUN_STOPPED;
					endcase
				end else if (cursor_q < last) begin
					cursor_d = cursor_q + FRAME_W'(1);
				end
			end else begin
				if (cursor_q == '0) begin
					pass_d = pass_inc;
					loop_d = loop_eff;
					case (loop_eff)
						LOOP_RESTART: cursor_d = last;
						LOOP_PINGPONG: begin
							rev_d = 1'b0;
							if (cursor_q < last) cursor_d = cursor_q + FRAME_W'(1);
						end
						default: run_d = RUN_STOPPED;
					endcase
				end else begin
					cursor_d = cursor_q - FRAME_W'(1);
				end
			end
		end
	end

	// The table is read at the cursor's next value, so the registered read
	// data always belongs to the current cursor.
	sasu_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_FRAMES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata({sprite_q, action_q}),
		.raddr(cursor_d),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q     <= cmd_t'(command);
			delta_q   <= delta_time;
			loop_in_q <= play_loop;
			rev_in_q  <= play_reverse;
			slot_q    <= frame_slot;
			sprite_q  <= sprite_value;
			action_q  <= action_value;
		end
		if (ctl.enter && fire) begin
			kind          <= 1'b0;
			action_frame  <= cursor_q;
			action_code   <= rd_action;
			sprite_index  <= '0;
			run_state     <= '0;
			current_frame <= '0;
			changed       <= 1'b0;
			last_result   <= 1'b0;
		end else if (ctl.emit_status) begin
			kind          <= 1'b1;
			action_frame  <= '0;
			action_code   <= '0;
			sprite_index  <= (nf != '0) ? rd_sprite : '0;
			run_state     <= run_q;
			current_frame <= cursor_q;
			changed       <= changed_q;
			last_result   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q   <= '0;
			frame_period_q  <= 16'd1000;
			max_cycles_q    <= '0;
			cursor_q        <= '0;
			entered_valid_q <= 1'b0;
			entered_q       <= '0;
			run_q           <= RUN_STOPPED;
			loop_q          <= LOOP_NONE;
			rev_q           <= 1'b0;
			pass_q          <= '0;
			accum_q         <= '0;
			changed_q       <= 1'b0;
			result_valid    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_FRAME_COUNT:  frame_count_q  <= cfg_data[COUNT_W-1:0];
					CFG_FRAME_PERIOD: frame_period_q <= cfg_data;
					CFG_MAX_CYCLES:   max_cycles_q   <= cfg_data;
					default: ;
				endcase
			end
			cursor_q        <= cursor_d;
			entered_valid_q <= entered_valid_d;
			entered_q       <= entered_d;
			run_q           <= run_d;
			loop_q          <= loop_d;
			rev_q           <= rev_d;
			pass_q          <= pass_d;
			accum_q         <= accum_d;
			changed_q       <= changed_d;
			result_valid    <= (ctl.enter && fire) || ctl.emit_status;
		end
	end

	`ASSERT_IMP(a_action_nonzero, clk, arst_n, result_valid && !kind, action_code != '0)
	`ASSERT_IMP(a_status_last, clk, arst_n, result_valid, kind == last_result)
	`ASSERT_IMP(a_cursor_range, clk, arst_n, nf != '0, cursor_q <= last)

endmodule

// ----- design/sprite_animation_sequencer_unit.sv -----
// Sprite animation frame sequencer. A command is taken when start is high
// and busy is low; busy then stays high until the command is finished, and
// every command ends with exactly one status result (kind high, last_result
// high). Results appear on the result ports for a single cycle, flagged by
// result_valid, and the receiver cannot stall them, so it must capture every
// transfer in the cycle it is shown. A load passes through an extra wait
// state, and the status of every command is on the result ports in the
// first cycle in which busy is low again. A tick while playing steps over
// at most MAX_STEPS frames, and ends early when a step runs off the end
// and stops the animation: each step moves the cursor in the step state,
// then reads the new frame from the single read port of the frame table
// and fires its action in the enter state. A tick that is refused costs
// as much as a plain command.
// Action results come out in frame order ahead of the status. Configuration
// writes are always ready and should only be made while busy is low and no
// result is still to come.
module sprite_animation_sequencer_unit import sasu_pkg::*; #(
	parameter int MAX_STEPS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          command,
	input  logic [TIME_W-1:0]   delta_time,
	input  logic [1:0]          play_loop,
	input  logic                play_reverse,
	input  logic [FRAME_W-1:0]  frame_slot,
	input  logic [SPRITE_W-1:0] sprite_value,
	input  logic [ACTION_W-1:0] action_value,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                result_valid,
	output logic                kind,
	output logic [FRAME_W-1:0]  action_frame,
	output logic [ACTION_W-1:0] action_code,
	output logic [SPRITE_W-1:0] sprite_index,
	output logic [1:0]          run_state,
	output logic [FRAME_W-1:0]  current_frame,
	output logic                changed,
	output logic                last_result
);

	ctl_t ctl;
	sts_t sts;

	// Registers are plain flops, so a write is always taken at once.
	assign cfg_ready = 1'b1;

	// The controller sequences execute, enter and step phases; the step
	// counter that caps frames per tick lives there.
	sasu_ctrl #(
		.MAX_STEPS(MAX_STEPS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.ctl   (ctl)
	);

	// The datapath holds the frame table, the playback state, the time
	// accumulator and the result register.
	sasu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.command      (command),
		.delta_time   (delta_time),
		.play_loop    (play_loop),
		.play_reverse (play_reverse),
		.frame_slot   (frame_slot),
		.sprite_value (sprite_value),
		.action_value (action_value),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.kind         (kind),
		.action_frame (action_frame),
		.action_code  (action_code),
		.sprite_index (sprite_index),
		.run_state    (run_state),
		.current_frame(current_frame),
		.changed      (changed),
		.last_result  (last_result)
	);

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the sprite animation frame sequencer.
module tb_top;
	import sasu_pkg::*;

	localparam int MAX_STEPS    = 32;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 280;
	localparam logic [ACCUM_W-1:0] ACCUM_CEIL = '1;

	// One command as the sender presents it. Fields that a command does not
	// use still carry random values, so that the block is seen to ignore them.
	typedef struct {
		cmd_t                cmd;
		logic [TIME_W-1:0]   delta;
		logic [1:0]          loop_sel;
		logic                reverse;
		logic [FRAME_W-1:0]  slot;
		logic [SPRITE_W-1:0] sprite;
		logic [ACTION_W-1:0] action;
	} command_item_t;

	// One result as it appears on the result ports.
	typedef struct packed {
		logic                kind;
		logic [FRAME_W-1:0]  action_frame;
		logic [ACTION_W-1:0] action_code;
		logic [SPRITE_W-1:0] sprite_index;
		logic [1:0]          run_state;
		logic [FRAME_W-1:0]  current_frame;
		logic                changed;
		logic                last_result;
	} seq_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [2:0]          command;
	logic [TIME_W-1:0]   delta_time;
	logic [1:0]          play_loop;
	logic                play_reverse;
	logic [FRAME_W-1:0]  frame_slot;
	logic [SPRITE_W-1:0] sprite_value;
	logic [ACTION_W-1:0] action_value;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_index;
	logic [15:0]         cfg_data;
	logic                result_valid;
	logic                kind;
	logic [FRAME_W-1:0]  action_frame;
	logic [ACTION_W-1:0] action_code;
	logic [SPRITE_W-1:0] sprite_index;
	logic [1:0]          run_state;
	logic [FRAME_W-1:0]  current_frame;
	logic                changed;
	logic                last_result;

	sprite_animation_sequencer_unit #(.MAX_STEPS(MAX_STEPS)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.delta_time    (delta_time),
		.play_loop     (play_loop),
		.play_reverse  (play_reverse),
		.frame_slot    (frame_slot),
		.sprite_value  (sprite_value),
		.action_value  (action_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.kind          (kind),
		.action_frame  (action_frame),
		.action_code   (action_code),
		.sprite_index  (sprite_index),
		.run_state     (run_state),
		.current_frame (current_frame),
		.changed       (changed),
		.last_result   (last_result)
	);

	// Shadow copy of the sequencer: frame table, cursor, play state and the
	// three settings. It is advanced at the edge where each transfer happens.
	logic [SPRITE_W-1:0] frame_sprite [MAX_FRAMES];
	logic [ACTION_W-1:0] frame_action [MAX_FRAMES];
	logic [FRAME_W-1:0]  seq_cursor;
	logic                seq_entered_ok;
	logic [FRAME_W-1:0]  seq_entered_at;
	run_t                seq_run;
	loop_t               seq_loop;
	logic                seq_back;
	logic [15:0]         seq_passes;
	logic [ACCUM_W-1:0]  seq_accum;
	logic [COUNT_W-1:0]  set_count;
	logic [15:0]         set_period;
	logic [15:0]         set_max_passes;

	// Results still owed by the block, oldest first.
	seq_result_t pending_results [$];
	seq_result_t seen;
	seq_result_t due;

	int  mismatches  = 0;
	int  items_sent  = 0;
	int  cycle_count = 0;
	// Set for the closing stretch of the run, where the sender takes no random idle gaps.
	bit  calm = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Counts above the table depth behave as a full table.
	function automatic int frames_in_use();
		return (set_count > MAX_FRAMES) ? MAX_FRAMES : int'(set_count);
	endfunction

	// Entering a frame that differs from the last one entered fires its action,
	// provided the action code is nonzero.
	function automatic void note_entry();
		seq_result_t r;
		if (!seq_entered_ok || seq_entered_at != seq_cursor) begin
			if (frame_action[seq_cursor] != '0) begin
				r = '0;
				r.action_frame = seq_cursor;
				r.action_code  = frame_action[seq_cursor];
				pending_results = {pending_results, r};
			end
			seq_entered_ok = 1'b1;
			seq_entered_at = seq_cursor;
		end
	endfunction

	// The pass counter saturates; reaching the pass limit drops out of looping.
	function automatic void close_pass();
		if (seq_passes != 16'hFFFF)
			seq_passes++;
		if (set_max_passes != 0 && seq_passes >= set_max_passes)
			seq_loop = LOOP_NONE;
	endfunction

	function automatic void step_cursor(int n);
		if (!seq_back) begin
			if (seq_cursor == n - 1) begin
				close_pass();
				case (seq_loop)
					LOOP_RESTART: seq_cursor = '0;
					LOOP_PINGPONG: begin
						seq_back = 1'b1;
						if (seq_cursor > 0)
							seq_cursor--;
					end
					default: seq_run = RUN_STOPPED;
				endcase
			end else if (seq_cursor < n - 1) begin
				seq_cursor++;
			end
		end else begin
			if (seq_cursor == 0) begin
				close_pass();
				case (seq_loop)
					// Running backwards, a restart jumps to the last frame.
					LOOP_RESTART: seq_cursor = 4'(n - 1);
					LOOP_PINGPONG: begin
						seq_back = 1'b0;
						if (seq_cursor < n - 1)
							seq_cursor++;
					end
					default: seq_run = RUN_STOPPED;
				endcase
			end else begin
				seq_cursor--;
			end
		end
	endfunction

	// Works out every result that one accepted command causes, in order.
	function automatic void play_out_command(command_item_t it);
		int                n;
		logic              chg;
		bit                done;
		int                steps;
		logic [ACCUM_W:0]  sum;
		seq_result_t       st;
		n = frames_in_use();
		chg = 1'b0;
		case (it.cmd)
			CMD_TICK: begin
				if (seq_run == RUN_PLAYING) begin
					chg = 1'b1;
					if (n == 0) begin
						seq_run = RUN_STOPPED;
					end else begin
						note_entry();
						sum = {1'b0, seq_accum} + it.delta;
						seq_accum = (sum > ACCUM_CEIL) ? ACCUM_CEIL : sum[ACCUM_W-1:0];
						done = 1'b0;
						steps = 0;
						while (!done && steps < MAX_STEPS) begin
							if (set_period == 0 || seq_accum < set_period) begin
								done = 1'b1;
							end else begin
								seq_accum = seq_accum - set_period;
								step_cursor(n);
								note_entry();
								if (seq_run == RUN_STOPPED)
									done = 1'b1;
								steps++;
							end
						end
					end
				end
			end
			CMD_PLAY: begin
				seq_run        = RUN_STOPPED;
				seq_loop       = LOOP_NONE;
				seq_back       = 1'b0;
				seq_entered_ok = 1'b0;
				seq_entered_at = '0;
				seq_passes     = '0;
				seq_accum      = '0;
				if (n != 0 && set_period != 0) begin
					// The unused loop code counts as no looping.
					seq_loop = (it.loop_sel > LOOP_PINGPONG) ? LOOP_NONE : loop_t'(it.loop_sel);
					seq_back = it.reverse;
					seq_run  = RUN_PLAYING;
				end
			end
			CMD_PAUSE: begin
				if (seq_run == RUN_PLAYING)
					seq_run = RUN_PAUSED;
			end
			CMD_RESUME: begin
				if (seq_run == RUN_PAUSED)
					seq_run = RUN_PLAYING;
			end
			CMD_STOP: seq_run = RUN_STOPPED;
			CMD_REW_START: seq_cursor = '0;
			CMD_REW_END: seq_cursor = (n > 0) ? 4'(n - 1) : 4'd0;
			CMD_LOAD: begin
				frame_sprite[it.slot] = it.sprite;
				frame_action[it.slot] = it.action;
			end
			default: ;
		endcase
		st = '0;
		st.kind          = 1'b1;
		st.sprite_index  = (n > 0) ? frame_sprite[seq_cursor] : '0;
		st.run_state     = seq_run;
		st.current_frame = seq_cursor;
		st.changed       = chg;
		st.last_result   = 1'b1;
		pending_results = {pending_results, st};
	endfunction

	// A lower frame count pulls the cursor back inside the frames in use.
	function automatic void apply_setting(cfg_idx_t idx, logic [15:0] value);
		int n;
		case (idx)
			CFG_FRAME_COUNT: begin
				set_count = value[COUNT_W-1:0];
				n = frames_in_use();
				if (n == 0)
					seq_cursor = '0;
				else if (seq_cursor >= n)
					seq_cursor = 4'(n - 1);
			end
			CFG_FRAME_PERIOD: set_period = value;
			CFG_MAX_CYCLES: set_max_passes = value;
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	function automatic string show_result(seq_result_t r);
		return $sformatf("kind=%0d frame=%0d code=%02h sprite=%04h state=%0d cursor=%0d chg=%0d last=%0d",
			r.kind, r.action_frame, r.action_code, r.sprite_index, r.run_state,
			r.current_frame, r.changed, r.last_result);
	endfunction

	function automatic void report_fault(string why, seq_result_t want, seq_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $time, why);
			$display("  expected %s", show_result(want));
			$display("  actual   %s", show_result(got));
		end
	endfunction

	// Results cannot be held off, so every cycle with result_valid high is a
	// transfer and is checked against the oldest pending result.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1) begin
			seen = {kind, action_frame, action_code, sprite_index, run_state,
				current_frame, changed, last_result};
			if (pending_results.size() == 0) begin
				report_fault("result with nothing pending", '0, seen);
			end else begin
				due = pending_results[0];
				pending_results.delete(0);
				if (seen.kind !== due.kind || seen.action_frame !== due.action_frame ||
						seen.action_code !== due.action_code ||
						seen.sprite_index !== due.sprite_index ||
						seen.run_state !== due.run_state ||
						seen.current_frame !== due.current_frame ||
						seen.changed !== due.changed ||
						seen.last_result !== due.last_result)
					report_fault("result mismatch", due, seen);
			end
		end
	end

	// Hard stop in case the block hangs or drops a result.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Every field filled at random; callers then set the ones that matter.
	function automatic command_item_t scrap_item(cmd_t c);
		command_item_t it;
		it.cmd      = c;
		it.delta    = 16'($urandom);
		it.loop_sel = 2'($urandom);
		it.reverse  = 1'($urandom);
		it.slot     = 4'($urandom);
		it.sprite   = 16'($urandom);
		it.action   = 8'($urandom);
		return it;
	endfunction

	task automatic drive_fields(command_item_t it);
		command      = it.cmd;
		delta_time   = it.delta;
		play_loop    = it.loop_sel;
		play_reverse = it.reverse;
		frame_slot   = it.slot;
		sprite_value = it.sprite;
		action_value = it.action;
	endtask

	// Presents one command and holds it until the block takes it. Start is
	// left high, so that back-to-back commands keep it high without a dip;
	// whoever idles next lowers it.
	task automatic issue_command(command_item_t it);
		@(negedge clk);
		drive_fields(it);
		start = 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		play_out_command(it);
		items_sent++;
	endtask

	task automatic send_tick(logic [TIME_W-1:0] dt);
		command_item_t it;
		it = scrap_item(CMD_TICK);
		it.delta = dt;
		issue_command(it);
	endtask

	task automatic send_play(logic [1:0] loop_sel, logic reverse);
		command_item_t it;
		it = scrap_item(CMD_PLAY);
		it.loop_sel = loop_sel;
		it.reverse  = reverse;
		issue_command(it);
	endtask

	task automatic send_ctrl(cmd_t c);
		issue_command(scrap_item(c));
	endtask

	task automatic send_load(logic [FRAME_W-1:0] slot, logic [SPRITE_W-1:0] sprite,
			logic [ACTION_W-1:0] action);
		command_item_t it;
		it = scrap_item(CMD_LOAD);
		it.slot   = slot;
		it.sprite = sprite;
		it.action = action;
		issue_command(it);
	endtask

	// Sender idles for a number of cycles, with noise on the idle fields.
	task automatic hold_off(int cycles);
		@(negedge clk);
		start = 1'b0;
		drive_fields(scrap_item(cmd_t'(3'($urandom))));
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	task automatic maybe_idle();
		if (!calm && $urandom_range(0, 2) == 0)
			hold_off($urandom_range(1, 9));
	endtask

	// Stops sending and waits for every owed result, plus a short margin so
	// that the block is idle before any setting changes.
	task automatic wait_for_quiet();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_setting(cfg_idx_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		apply_setting(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// The first four frames are filled with the extremes of sprite and action.
	// The frame count stays at zero, so no status reads the table yet.
	task automatic test_table_setup();
		send_load(4'd0, 16'h0000, 8'hFF);
		send_load(4'd1, 16'hFFFF, 8'h00);
		send_load(4'd2, 16'hA5A5, 8'h01);
		send_load(4'd3, 16'h5A5A, 8'h80);
	endtask

	// Play is refused with no frames and again with a zero period; a tick
	// while stopped changes nothing.
	task automatic test_refused_play();
		send_play(LOOP_RESTART, 1'b0);
		send_tick(16'hFFFF);
		wait_for_quiet();
		write_setting(CFG_FRAME_COUNT, 16'd4);
		write_setting(CFG_FRAME_PERIOD, 16'd0);
		send_play(LOOP_NONE, 1'b0);
		wait_for_quiet();
		write_setting(CFG_FRAME_PERIOD, 16'd10);
	endtask

	// One forward pass with pause and resume; the last tick runs off the end
	// and the sequence stops on the final frame.
	task automatic test_forward_once();
		send_play(LOOP_NONE, 1'b0);
		send_tick(16'd25);
		send_ctrl(CMD_PAUSE);
		send_tick(16'd100);
		send_ctrl(CMD_RESUME);
		send_tick(16'hFFFF);
	endtask

	// Backwards restart from frame 0 jumps to the last frame; the pass limit
	// then ends the loop.
	task automatic test_reverse_restart();
		wait_for_quiet();
		write_setting(CFG_MAX_CYCLES, 16'd2);
		send_play(LOOP_RESTART, 1'b1);
		send_ctrl(CMD_REW_START);
		send_tick(16'd10);
		send_tick(16'hFFFF);
	endtask

	task automatic test_pingpong();
		wait_for_quiet();
		write_setting(CFG_MAX_CYCLES, 16'hFFFF);
		send_play(LOOP_PINGPONG, 1'b0);
		send_tick(16'd200);
		send_ctrl(CMD_REW_END);
		send_ctrl(CMD_STOP);
	endtask

	// The spare loop code must behave as no looping.
	task automatic test_loop_mode_three();
		wait_for_quiet();
		write_setting(CFG_MAX_CYCLES, 16'd0);
		send_play(2'd3, 1'b1);
		send_tick(16'hFFFF);
	endtask

	// Lowering the frame count drags the cursor in; a count of zero while
	// playing stops the sequence on the next tick.
	task automatic test_frame_count_changes();
		send_play(LOOP_RESTART, 1'b0);
		send_tick(16'd15);
		send_ctrl(CMD_REW_END);
		wait_for_quiet();
		write_setting(CFG_FRAME_COUNT, 16'd2);
		send_tick(16'd10);
		wait_for_quiet();
		write_setting(CFG_FRAME_COUNT, 16'd0);
		send_tick(16'd1);
	endtask

	// With a zero period time piles up until the accumulator saturates; a
	// small period afterwards lets one tick take the full step budget.
	task automatic saturate_accumulator();
		wait_for_quiet();
		write_setting(CFG_FRAME_COUNT, 16'($urandom_range(2, 16)));
		write_setting(CFG_FRAME_PERIOD, 16'($urandom_range(1, 9)));
		write_setting(CFG_MAX_CYCLES, 16'd0);
		send_play(2'($urandom_range(1, 2)), 1'($urandom));
		wait_for_quiet();
		write_setting(CFG_FRAME_PERIOD, 16'd0);
		repeat (24) begin
			maybe_idle();
			send_tick(16'($urandom_range(49152, 65535)));
		end
		wait_for_quiet();
		write_setting(CFG_FRAME_PERIOD, 16'($urandom_range(1, 3)));
		send_tick(16'd0);
		send_tick(16'($urandom));
	endtask

	// One stretch of random traffic under fresh settings. Most stretches open
	// with a play so that the ticks reach deep into stepping and looping.
	task automatic random_phase(bit write_all);
		int len;
		int pick;
		int p;
		int d;
		wait_for_quiet();
		pick = $urandom_range(0, 19);
		if (write_all || $urandom_range(0, 2) != 0)
			write_setting(CFG_FRAME_COUNT,
				(pick == 0) ? 16'd0 : (pick == 1) ? 16'd16 :
				(pick == 2) ? 16'($urandom_range(17, 31)) :
				(pick < 6) ? 16'($urandom_range(1, 3)) : 16'($urandom_range(2, 16)));
		pick = $urandom_range(0, 19);
		if (write_all || $urandom_range(0, 2) != 0)
			write_setting(CFG_FRAME_PERIOD,
				(pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd1 : (pick == 2) ? 16'd0 :
				(pick < 5) ? 16'($urandom_range(41, 3000)) : 16'($urandom_range(2, 40)));
		pick = $urandom_range(0, 9);
		if (write_all || $urandom_range(0, 2) != 0)
			write_setting(CFG_MAX_CYCLES,
				(pick == 0) ? 16'hFFFF : (pick < 5) ? 16'($urandom_range(1, 4)) : 16'd0);
		if ($urandom_range(0, 9) != 0) begin
			maybe_idle();
			send_play(2'($urandom), 1'($urandom));
		end
		len = $urandom_range(8, 24);
		repeat (len) begin
			maybe_idle();
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				// Deltas mostly sized to the period, some raw, some large
				// enough to hit the per-tick step budget.
				p = set_period;
				pick = $urandom_range(0, 9);
				if (p == 0 || pick < 2)
					d = $urandom_range(0, 65535);
				else if (pick < 7)
					d = p * $urandom_range(0, 4) + $urandom_range(0, p - 1);
				else if (pick < 8)
					d = 0;
				else
					d = p * $urandom_range(30, 40);
				send_tick((d > 65535) ? 16'hFFFF : 16'(d));
			end else if (pick < 68) begin
				send_ctrl(CMD_PAUSE);
			end else if (pick < 74) begin
				send_ctrl(CMD_RESUME);
			end else if (pick < 78) begin
				send_ctrl(CMD_STOP);
			end else if (pick < 82) begin
				send_ctrl(CMD_REW_START);
			end else if (pick < 86) begin
				send_ctrl(CMD_REW_END);
			end else if (pick < 92) begin
				send_load(4'($urandom), 16'($urandom),
					($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
			end else begin
				send_play(2'($urandom), 1'($urandom));
			end
		end
	endtask

	// The rest of the table is filled before any count above four is used,
	// then random stretches run until enough commands have gone through.
	task automatic test_random_sequences();
		int first;
		int phase;
		first = items_sent;
		for (int s = 4; s < MAX_FRAMES; s++)
			send_load(4'(s), 16'($urandom), ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
		phase = 0;
		while (items_sent - first < RANDOM_ITEMS) begin
			calm = (items_sent - first > RANDOM_ITEMS - 50);
			if (phase == 3 || (phase > 6 && !calm && $urandom_range(0, 11) == 0))
				saturate_accumulator();
			else
				random_phase(phase == 0);
			phase++;
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------

	initial begin
		start        = 1'b0;
		command      = CMD_TICK;
		delta_time   = '0;
		play_loop    = '0;
		play_reverse = 1'b0;
		frame_slot   = '0;
		sprite_value = '0;
		action_value = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_FRAME_COUNT;
		cfg_data     = '0;
		arst_n       = 1'b0;

		// Shadow state as the block comes out of reset.
		for (int i = 0; i < MAX_FRAMES; i++) begin
			frame_sprite[i] = '0;
			frame_action[i] = '0;
		end
		seq_cursor     = '0;
		seq_entered_ok = 1'b0;
		seq_entered_at = '0;
		seq_run        = RUN_STOPPED;
		seq_loop       = LOOP_NONE;
		seq_back       = 1'b0;
		seq_passes     = '0;
		seq_accum      = '0;
		set_count      = '0;
		set_period     = 16'd1000;
		set_max_passes = '0;

		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_table_setup();
		test_refused_play();
		test_forward_once();
		test_reverse_restart();
		test_pingpong();
		test_loop_mode_three();
		test_frame_count_changes();
		test_random_sequences();

		// Drain, then allow the longest tick time to show any stray result.
		wait_for_quiet();
		repeat (80)
			@(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
